// ===== hw/rtl/stsh_pkg.sv =====
// ----------------------------------------------------------------------------
// stsh_pkg
// Shared types, register codes and defaults for the stop-triggered sample
// history dump.
// ----------------------------------------------------------------------------
package stsh_pkg;

   // Ring and dump geometry defaults.
   localparam int HISTORY_DEPTH_DEF = 150;
   localparam int SKIP_RECENT_DEF   = 50;
   localparam int DUMP_SAMPLES_DEF  = 100;

   // Depth of the command and result queues.
   localparam int QUEUE_DEPTH_DEF   = 2;

   // Register reset values.
   localparam logic [7:0] SPIKE_LIMIT_RESET    = 8'd250;
   localparam logic [7:0] RUN_THRESHOLD_RESET  = 8'd50;
   localparam logic [7:0] STOP_THRESHOLD_RESET = 8'd50;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPIKE_LIMIT    = 2'd0,
      CSR_RUN_THRESHOLD  = 2'd1,
      CSR_STOP_THRESHOLD = 2'd2
   } csr_index_type;

   // Status byte bit positions.
   localparam int ST_BRAKE      = 7;
   localparam int ST_LEFT_TURN  = 6;
   localparam int ST_RIGHT_TURN = 5;
   localparam int ST_HIGH_BEAM  = 4;
   localparam int ST_LOW_BEAM   = 3;
   localparam int ST_IGNITION   = 0;

   typedef struct packed {
      logic [7:0] spike_limit;
      logic [7:0] run_threshold;
      logic [7:0] stop_threshold;
   } cfg_type;

   typedef struct packed {
      logic       ignition_on;
      logic [7:0] speed;
      logic       brake;
      logic       left_turn;
      logic       right_turn;
      logic       high_beam;
      logic       low_beam;
   } tick_type;

   typedef struct packed {
      logic [7:0] speed;
      logic [7:0] status;
   } sample_type;

   // One classified tick: the sample to store and whether it starts a dump.
   typedef struct packed {
      sample_type sample;
      logic       trigger;
   } cmd_type;

   typedef struct packed {
      sample_type first;
      sample_type second;
      logic       dump_last;
   } result_type;

   typedef enum logic [1:0] {
      BK_IDLE      = 2'd0,
      BK_RD_FIRST  = 2'd1,
      BK_RD_SECOND = 2'd2,
      BK_EMIT      = 2'd3
   } back_state_type;

   typedef struct packed {
      logic dumping;
      logic cmd_pop;
      logic rsp_push;
      logic rsp_last;
   } back_status_type;

endpackage

// ===== hw/rtl/stsh_fifo.sv =====
// ----------------------------------------------------------------------------
// stsh_fifo
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module stsh_fifo #(
   parameter int WIDTH = 16,
   parameter int DEPTH = stsh_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

// ===== hw/rtl/stsh_front.sv =====
// ----------------------------------------------------------------------------
// stsh_front
// Tick classifier: spike filter, status packing, motion and stop counters.
// ----------------------------------------------------------------------------
module stsh_front (
   input  logic               clock,
   input  logic               reset,
   input  stsh_pkg::cfg_type  cfg,
   input  logic               tick_accept,
   input  stsh_pkg::tick_type tick,
   output logic               cmd_push,
   output stsh_pkg::cmd_type  cmd
);
   logic [7:0] prev_speed_ff, prev_speed_in;
   logic [7:0] moving_count_ff, moving_count_in;
   logic [7:0] stopped_count_ff, stopped_count_in;
   logic       moving_ff, moving_in;
   logic       sample_tick;
   logic [7:0] stored;
   logic       trigger;

   // Ignition off drops the tick altogether.
   assign sample_tick = tick_accept && tick.ignition_on;
   assign stored      = (tick.speed > cfg.spike_limit) ? prev_speed_ff : tick.speed;

   always_comb begin
      prev_speed_in    = prev_speed_ff;
      moving_count_in  = moving_count_ff;
      stopped_count_in = stopped_count_ff;
      moving_in        = moving_ff;
      trigger          = 1'b0;
      if (sample_tick) begin
         prev_speed_in = stored;
         if (tick.speed != 8'd0) begin
            stopped_count_in = 8'd0;
            if (moving_count_ff < cfg.run_threshold) begin
               moving_count_in = moving_count_ff + 8'd1;
            end else begin
               moving_in = 1'b1;
            end
         end else begin
            moving_count_in = 8'd0;
            if (stopped_count_ff < cfg.stop_threshold) begin
               stopped_count_in = stopped_count_ff + 8'd1;
            end else begin
               trigger   = moving_ff;
               moving_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      cmd.sample.speed                        = stored;
      cmd.sample.status                       = 8'd0;
      cmd.sample.status[stsh_pkg::ST_BRAKE]     = tick.brake;
      cmd.sample.status[stsh_pkg::ST_LEFT_TURN] = tick.left_turn;
      cmd.sample.status[stsh_pkg::ST_RIGHT_TURN] = tick.right_turn;
      cmd.sample.status[stsh_pkg::ST_HIGH_BEAM] = tick.high_beam;
      cmd.sample.status[stsh_pkg::ST_LOW_BEAM]  = tick.low_beam;
      cmd.sample.status[stsh_pkg::ST_IGNITION]  = 1'b1;
      cmd.trigger                             = trigger;
   end

   assign cmd_push = sample_tick;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_speed_ff    <= 8'd0;
         moving_count_ff  <= 8'd0;
         stopped_count_ff <= 8'd0;
         moving_ff        <= 1'b0;
      end else begin
         prev_speed_ff    <= prev_speed_in;
         moving_count_ff  <= moving_count_in;
         stopped_count_ff <= stopped_count_in;
         moving_ff        <= moving_in;
      end
   end

endmodule

// ===== hw/rtl/stsh_back.sv =====
// ----------------------------------------------------------------------------
// stsh_back
// History ring and dump sequencer: stores samples, walks the ring on a trigger.
// ----------------------------------------------------------------------------
module stsh_back #(
   parameter int HISTORY_DEPTH = stsh_pkg::HISTORY_DEPTH_DEF,
   parameter int SKIP_RECENT   = stsh_pkg::SKIP_RECENT_DEF,
   parameter int DUMP_SAMPLES  = stsh_pkg::DUMP_SAMPLES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_empty,
   input  stsh_pkg::cmd_type         cmd,
   output logic                      cmd_pop,
   input  logic                      rsp_full,
   output logic                      rsp_push,
   output stsh_pkg::result_type      rsp,
   output stsh_pkg::back_status_type status
);
   localparam int PTR_W = $clog2(HISTORY_DEPTH);
   localparam int SUM_W = PTR_W + 1;
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int CNT_W = $clog2(DUMP_SAMPLES + 2) + 1;
   localparam int SKIP_MOD = SKIP_RECENT % HISTORY_DEPTH;

   logic [15:0] ring_mem [HISTORY_DEPTH];

   stsh_pkg::back_state_type state_ff, state_in;
   logic [PTR_W-1:0]  slot_ff, slot_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   stsh_pkg::sample_type first_ff, first_in;
   logic [15:0]       rd_data_ff;
   logic              rd_valid_ff;

   logic              mem_we;
   logic              rd_en;
   logic              has_second;
   logic              is_last;
   logic [SUM_W-1:0]  start_sum;
   logic [PTR_W-1:0]  start_ptr;
   logic [PTR_W-1:0]  ptr_dec;
   stsh_pkg::sample_type rd_sample;

   assign has_second = (cnt_ff + CNT_W'(1)) < CNT_W'(DUMP_SAMPLES);
   assign is_last    = (cnt_ff + CNT_W'(2)) >= CNT_W'(DUMP_SAMPLES);

   // Newest-first start slot: newest sample sits at slot_ff, step back past the skip.
   assign start_sum = SUM_W'(slot_ff) + SUM_W'(HISTORY_DEPTH) - SUM_W'(SKIP_MOD);
   assign start_ptr = (start_sum >= SUM_W'(HISTORY_DEPTH)) ?
                      PTR_W'(start_sum - SUM_W'(HISTORY_DEPTH)) : PTR_W'(start_sum);
   assign ptr_dec   = (rd_ptr_ff == '0) ? PTR_W'(HISTORY_DEPTH - 1) : rd_ptr_ff - 1'b1;

   // Never-written entries read as zero.
   assign rd_sample = rd_valid_ff ? stsh_pkg::sample_type'(rd_data_ff) : '0;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stsh_pkg::BK_IDLE: begin
            if (!cmd_empty && cmd.trigger) begin
               state_in = stsh_pkg::BK_RD_FIRST;
            end
         end
         stsh_pkg::BK_RD_FIRST:  state_in = stsh_pkg::BK_RD_SECOND;
         stsh_pkg::BK_RD_SECOND: state_in = stsh_pkg::BK_EMIT;
         stsh_pkg::BK_EMIT: begin
            if (!rsp_full) begin
               state_in = is_last ? stsh_pkg::BK_IDLE : stsh_pkg::BK_RD_FIRST;
            end
         end
         default: state_in = stsh_pkg::BK_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd_pop  = 1'b0;
      mem_we   = 1'b0;
      rd_en    = 1'b0;
      rsp_push = 1'b0;
      case (state_ff)
         stsh_pkg::BK_IDLE: begin
            cmd_pop = !cmd_empty;
            mem_we  = !cmd_empty;
         end
         stsh_pkg::BK_RD_FIRST:  rd_en    = 1'b1;
         stsh_pkg::BK_RD_SECOND: rd_en    = has_second;
         stsh_pkg::BK_EMIT:      rsp_push = !rsp_full;
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp.first     = first_ff;
      rsp.second    = has_second ? rd_sample : '0;
      rsp.dump_last = is_last;
   end

   // Datapath next values.
   always_comb begin
      slot_in   = slot_ff;
      fill_in   = fill_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      first_in  = first_ff;
      if (mem_we) begin
         slot_in = (slot_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
         if (fill_ff != FILL_W'(HISTORY_DEPTH)) begin
            fill_in = fill_ff + 1'b1;
         end
         rd_ptr_in = start_ptr;
         cnt_in    = '0;
      end
      if (rd_en) begin
         rd_ptr_in = ptr_dec;
      end
      if (state_ff == stsh_pkg::BK_RD_SECOND) begin
         first_in = rd_sample;
      end
      if (rsp_push) begin
         cnt_in = cnt_ff + CNT_W'(2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stsh_pkg::BK_IDLE;
         slot_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      cnt_ff    <= cnt_in;
      first_ff  <= first_in;
   end

   // Ring memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[slot_ff] <= cmd.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= ring_mem[rd_ptr_ff];
         rd_valid_ff <= (FILL_W'(rd_ptr_ff) < fill_ff);
      end
   end

   always_comb begin
      status.dumping  = (state_ff != stsh_pkg::BK_IDLE);
      status.cmd_pop  = cmd_pop;
      status.rsp_push = rsp_push;
      status.rsp_last = rsp.dump_last;
   end

endmodule

// ===== hw/rtl/stop_triggered_sample_history_dump.sv =====
// ----------------------------------------------------------------------------
// stop_triggered_sample_history_dump
// Pre-trigger capture of speed and lamp status, dumped on a stop after motion.
// ----------------------------------------------------------------------------
// Each request is one 0.2 s tick. A front classifier takes a tick whenever the
// two-entry command queue has room (req_full low), filters speed spikes, packs
// the status byte and runs the moving/stopped counters; ticks with ignition off
// are dropped there. A back sequencer drains the queue: a plain tick costs it one
// ring write. A triggering tick writes its sample and then walks the ring newest
// first, skipping SKIP_RECENT samples and reading DUMP_SAMPLES more through the
// single registered read port of the ring memory; for each result pair it reads
// in BK_RD_FIRST and BK_RD_SECOND, then pushes in BK_EMIT, where it waits while
// the result queue is full. The ring is not swept at reset: a fill count marks
// which slots hold data and the rest read as zero, so the block accepts ticks
// right after reset. The user must write registers through csr_* only while
// the block is idle, which the block does not enforce; csr_ready is always high.
// ----------------------------------------------------------------------------
module stop_triggered_sample_history_dump #(
   parameter int HISTORY_DEPTH = stsh_pkg::HISTORY_DEPTH_DEF,
   parameter int SKIP_RECENT   = stsh_pkg::SKIP_RECENT_DEF,
   parameter int DUMP_SAMPLES  = stsh_pkg::DUMP_SAMPLES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // tick requests
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_ignition_on,
   input  logic [7:0] req_speed,
   input  logic       req_brake,
   input  logic       req_left_turn,
   input  logic       req_right_turn,
   input  logic       req_high_beam,
   input  logic       req_low_beam,
   // dump results
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_first_speed,
   output logic [7:0] rsp_first_status,
   output logic [7:0] rsp_second_speed,
   output logic [7:0] rsp_second_status,
   output logic       rsp_dump_last,
   // register writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [stsh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0] csr_data
);
   localparam int CMD_W = $bits(stsh_pkg::cmd_type);
   localparam int RSP_W = $bits(stsh_pkg::result_type);

   stsh_pkg::cfg_type         cfg_ff, cfg_in;
   stsh_pkg::tick_type        tick;
   stsh_pkg::cmd_type         cmd_front;
   stsh_pkg::cmd_type         cmd_back;
   stsh_pkg::result_type      rsp_back;
   stsh_pkg::result_type      rsp_head;
   stsh_pkg::back_status_type bk_status;
   logic                      tick_accept;
   logic                      cmd_push;
   logic                      cmd_pop;
   logic                      cmd_empty;
   logic                      rsp_push;
   logic                      rsp_full;
   logic [CMD_W-1:0]          cmd_head_bits;
   logic [RSP_W-1:0]          rsp_head_bits;

   // ---- register file: always ready, unknown indexes are dropped ----
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (stsh_pkg::csr_index_type'(csr_index))
            stsh_pkg::CSR_SPIKE_LIMIT:    cfg_in.spike_limit    = csr_data;
            stsh_pkg::CSR_RUN_THRESHOLD:  cfg_in.run_threshold  = csr_data;
            stsh_pkg::CSR_STOP_THRESHOLD: cfg_in.stop_threshold = csr_data;
            default:                      cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spike_limit    <= stsh_pkg::SPIKE_LIMIT_RESET;
         cfg_ff.run_threshold  <= stsh_pkg::RUN_THRESHOLD_RESET;
         cfg_ff.stop_threshold <= stsh_pkg::STOP_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- front: classify each accepted tick ----
   assign tick_accept = req_push && !req_full;

   always_comb begin
      tick.ignition_on = req_ignition_on;
      tick.speed       = req_speed;
      tick.brake       = req_brake;
      tick.left_turn   = req_left_turn;
      tick.right_turn  = req_right_turn;
      tick.high_beam   = req_high_beam;
      tick.low_beam    = req_low_beam;
   end

   stsh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .tick_accept (tick_accept),
      .tick        (tick),
      .cmd_push    (cmd_push),
      .cmd         (cmd_front)
   );

   // ---- command queue: lets the front run ahead of a dump ----
   stsh_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (stsh_pkg::QUEUE_DEPTH_DEF)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .data_in  (cmd_front),
      .full     (req_full),
      .pop      (cmd_pop),
      .data_out (cmd_head_bits),
      .empty    (cmd_empty)
   );

   assign cmd_back = stsh_pkg::cmd_type'(cmd_head_bits);

   // ---- back: ring write and dump walk ----
   stsh_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SKIP_RECENT   (SKIP_RECENT),
      .DUMP_SAMPLES  (DUMP_SAMPLES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_back),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_back),
      .status    (bk_status)
   );

   // ---- result queue: hold finished pairs until the consumer pops ----
   stsh_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (stsh_pkg::QUEUE_DEPTH_DEF)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .data_in  (rsp_back),
      .full     (rsp_full),
      .pop      (rsp_pop),
      .data_out (rsp_head_bits),
      .empty    (rsp_empty)
   );

   assign rsp_head          = stsh_pkg::result_type'(rsp_head_bits);
   assign rsp_first_speed   = rsp_head.first.speed;
   assign rsp_first_status  = rsp_head.first.status;
   assign rsp_second_speed  = rsp_head.second.speed;
   assign rsp_second_status = rsp_head.second.status;
   assign rsp_dump_last     = rsp_head.dump_last;

   // ---- checks ----
   // The final pair of a dump returns the sequencer to idle.
   a_last_ends_dump: assert property (@(posedge clock) disable iff (reset)
      bk_status.rsp_push && bk_status.rsp_last |=> !bk_status.dumping)
      else $error("dump sequencer still busy after final result");

   // No new tick is taken off the queue while a dump walks the ring.
   a_no_pop_in_dump: assert property (@(posedge clock) disable iff (reset)
      bk_status.dumping |-> !bk_status.cmd_pop)
      else $error("command popped during dump");

   // Results are only produced into a queue with room.
   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      bk_status.rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");

   // A tick with ignition off never reaches the back end.
   a_ignition_off_dropped: assert property (@(posedge clock) disable iff (reset)
      tick_accept && !req_ignition_on |-> !cmd_push)
      else $error("ignition-off tick queued");

endmodule

// ===== test/tb_stop_triggered_sample_history_dump.sv =====
// ----------------------------------------------------------------------------
// tb_stop_triggered_sample_history_dump
// Self-checking bench for the stop-triggered sample history dump.
// ----------------------------------------------------------------------------
// Tick requests go in through the push/full port. A scoreboard tracks the
// sample ring, the spike filter and the moving/stopped counters, and it queues
// the pairs that each triggering tick must dump. Every popped pair is checked
// field by field against the oldest queued pair. Register settings change only
// between phases, once all queued pairs have drained.
// ----------------------------------------------------------------------------
module tb_stop_triggered_sample_history_dump;
   timeunit 1ns;
   timeprecision 1ps;

   import stsh_pkg::*;

   localparam int RING_DEPTH  = HISTORY_DEPTH_DEF;
   localparam int SKIP_NEWEST = SKIP_RECENT_DEF;
   localparam int DUMP_LEN    = DUMP_SAMPLES_DEF;

   // Register index past the end of the map; writes to it must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   // Settle time for plain ticks to clear the two-entry command queue.
   localparam int SETTLE_CYCLES = 20;
   // Wait at the end for longer than a dump takes to walk the ring.
   localparam int TAIL_CYCLES   = 200;
   // Cycles with no handshake at all before the run is declared hung.
   localparam int STALL_LIMIT   = 2000;

   // -------------------------------------------------------------------------
   // Scoreboard: mirror of ring, filter and counters, plus the pairs due.
   // -------------------------------------------------------------------------
   class dump_scoreboard;
      sample_type  ring [RING_DEPTH];
      int unsigned next_slot;
      logic [7:0]  held_speed;
      logic [7:0]  moving_run;
      logic [7:0]  stopped_run;
      bit          moving;
      cfg_type     cfg;
      result_type  pairs_due[$];
      int          mismatches;

      function new();
         foreach (ring[i]) ring[i] = '0;
         next_slot       = 0;
         held_speed      = '0;
         moving_run      = '0;
         stopped_run     = '0;
         moving          = 1'b0;
         cfg.spike_limit    = SPIKE_LIMIT_RESET;
         cfg.run_threshold  = RUN_THRESHOLD_RESET;
         cfg.stop_threshold = STOP_THRESHOLD_RESET;
         mismatches      = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [7:0] value);
         case (index)
            CSR_SPIKE_LIMIT:    cfg.spike_limit    = value;
            CSR_RUN_THRESHOLD:  cfg.run_threshold  = value;
            CSR_STOP_THRESHOLD: cfg.stop_threshold = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return pairs_due.size();
      endfunction

      // k = 0 is the newest stored sample
      function sample_type back_from_newest(int unsigned k);
         return ring[(next_slot + RING_DEPTH - 1 - (k % RING_DEPTH)) % RING_DEPTH];
      endfunction

      // Note one accepted tick and queue the pairs of any dump it starts.
      function void log_tick(tick_type t);
         sample_type s;
         bit         stop_seen;
         result_type pair;
         if (!t.ignition_on)
            return;
         s.status                = '0;
         s.status[ST_BRAKE]      = t.brake;
         s.status[ST_LEFT_TURN]  = t.left_turn;
         s.status[ST_RIGHT_TURN] = t.right_turn;
         s.status[ST_HIGH_BEAM]  = t.high_beam;
         s.status[ST_LOW_BEAM]   = t.low_beam;
         s.status[ST_IGNITION]   = 1'b1;
         // drop a spike: keep the previous stored speed instead
         s.speed    = (t.speed > cfg.spike_limit) ? held_speed : t.speed;
         held_speed = s.speed;
         ring[next_slot] = s;
         next_slot  = (next_slot + 1) % RING_DEPTH;

         // counters follow the raw speed, not the filtered one
         stop_seen = 1'b0;
         if (t.speed != 8'd0) begin
            stopped_run = '0;
            if (moving_run < cfg.run_threshold)
               moving_run++;
            else
               moving = 1'b1;
         end else begin
            moving_run = '0;
            if (stopped_run < cfg.stop_threshold) begin
               stopped_run++;
            end else begin
               stop_seen = moving;
               moving    = 1'b0;
            end
         end
         if (!stop_seen)
            return;

         for (int k = 0; k < DUMP_LEN; k += 2) begin
            pair.first     = back_from_newest(SKIP_NEWEST + k);
            pair.second    = (k + 1 < DUMP_LEN) ? back_from_newest(SKIP_NEWEST + k + 1)
                                                : sample_type'(0);
            pair.dump_last = (k + 2 >= DUMP_LEN);
            pairs_due.push_back(pair);
         end
      endfunction

      function void report(string field, logic [7:0] want_v, logic [7:0] got_v);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
      endfunction

      function void check_pair(result_type got);
         result_type want;
         if (pairs_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: dump pair with none pending, first_speed %0d first_status %0d",
                        $time, got.first.speed, got.first.status);
            return;
         end
         want = pairs_due.pop_front();
         if (got.first.speed !== want.first.speed)
            report("first_speed", want.first.speed, got.first.speed);
         if (got.first.status !== want.first.status)
            report("first_status", want.first.status, got.first.status);
         if (got.second.speed !== want.second.speed)
            report("second_speed", want.second.speed, got.second.speed);
         if (got.second.status !== want.second.status)
            report("second_status", want.second.status, got.second.status);
         if (got.dump_last !== want.dump_last)
            report("dump_last", 8'(want.dump_last), 8'(got.dump_last));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic                   clock;
   logic                   reset;
   logic                   req_push;
   logic                   req_full;
   logic                   req_ignition_on;
   logic [7:0]             req_speed;
   logic                   req_brake;
   logic                   req_left_turn;
   logic                   req_right_turn;
   logic                   req_high_beam;
   logic                   req_low_beam;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic [7:0]             rsp_first_speed;
   logic [7:0]             rsp_first_status;
   logic [7:0]             rsp_second_speed;
   logic [7:0]             rsp_second_status;
   logic                   rsp_dump_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_data;

   stop_triggered_sample_history_dump dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_ignition_on   (req_ignition_on),
      .req_speed         (req_speed),
      .req_brake         (req_brake),
      .req_left_turn     (req_left_turn),
      .req_right_turn    (req_right_turn),
      .req_high_beam     (req_high_beam),
      .req_low_beam      (req_low_beam),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_first_speed   (rsp_first_speed),
      .rsp_first_status  (rsp_first_status),
      .rsp_second_speed  (rsp_second_speed),
      .rsp_second_status (rsp_second_status),
      .rsp_dump_last     (rsp_dump_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   dump_scoreboard sb;
   bit             tx_steady = 1'b0;   // sender runs without gaps while set
   bit             rx_steady = 1'b0;   // receiver pops without stalls while set
   int             idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Hang detection: count cycles in which no handshake completes.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= STALL_LIMIT);
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers. Drive at the falling edge, sample at the rising edge.
   // -------------------------------------------------------------------------
   function automatic tick_type tick_of(bit ign, logic [7:0] speed, logic [4:0] lamps);
      tick_type t;
      t.ignition_on = ign;
      t.speed       = speed;
      {t.brake, t.left_turn, t.right_turn, t.high_beam, t.low_beam} = lamps;
      return t;
   endfunction

   // Bias toward the top and bottom of the speed range.
   function automatic logic [7:0] nonzero_speed();
      case ($urandom_range(0, 7))
         0:       return 8'd255;
         1:       return 8'd1;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // Push one tick request and hold it until the queue takes it.
   task automatic send_tick(tick_type t);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ignition_on <= t.ignition_on;
      req_speed       <= t.speed;
      req_brake       <= t.brake;
      req_left_turn   <= t.left_turn;
      req_right_turn  <= t.right_turn;
      req_high_beam   <= t.high_beam;
      req_low_beam    <= t.low_beam;
      req_push        <= 1'b1;
      do @(posedge clock); while (req_full);
      sb.log_tick(t);
   endtask

   // Send a run of moving or standing ticks with random lamps; sprinkle in
   // ignition-off ticks, which must leave the run unbroken.
   task automatic send_run(bit rolling, int len, int quota, ref int sent);
      logic [7:0] spd;
      for (int i = 0; i < len && sent < quota; i++) begin
         if ($urandom_range(0, 11) == 0)
            send_tick(tick_of(1'b0, 8'($urandom), 5'($urandom)));
         spd = rolling ? nonzero_speed() : 8'd0;
         send_tick(tick_of(1'b1, spd, 5'($urandom)));
         sent++;
      end
   endtask

   // Hold requests off until every queued pair has been popped.
   task automatic wait_for_dumps(int settle);
      @(negedge clock);
      req_push <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(logic [7:0] spike, logic [7:0] run_th, logic [7:0] stop_th);
      write_csr(CSR_SPIKE_LIMIT, spike);
      write_csr(CSR_RUN_THRESHOLD, run_th);
      write_csr(CSR_STOP_THRESHOLD, stop_th);
   endtask

   // Random phase: mostly full drive-then-stop cycles so that dumps happen,
   // plus cut-short runs, noise and the odd full drain of the result side.
   task automatic run_phase(int quota);
      int sent;
      int kind;
      int len;
      sent = 0;
      while (sent < quota) begin
         kind      = $urandom_range(0, 9);
         tx_steady = ($urandom_range(0, 3) == 0);
         if (kind <= 5) begin
            send_run(1'b1, sb.cfg.run_threshold + 1 + $urandom_range(0, 3), quota, sent);
            send_run(1'b0, sb.cfg.stop_threshold + 1 + $urandom_range(0, 3), quota, sent);
         end else if (kind == 6) begin
            // motion that never reaches the run threshold, then a stop
            send_run(1'b1, $urandom_range(1, sb.cfg.run_threshold), quota, sent);
            send_run(1'b0, sb.cfg.stop_threshold + 1, quota, sent);
         end else if (kind == 7) begin
            // stop that ends before the stop threshold
            send_run(1'b0, $urandom_range(1, sb.cfg.stop_threshold), quota, sent);
         end else if (kind == 8) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len && sent < quota; i++) begin
               if ($urandom_range(0, 3) == 0) begin
                  send_tick(tick_of(1'b0, 8'($urandom), 5'($urandom)));
               end else begin
                  send_tick(tick_of(1'b1, $urandom_range(0, 1) ? nonzero_speed() : 8'd0,
                                    5'($urandom)));
                  sent++;
               end
            end
         end else begin
            wait_for_dumps(0);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Result side: pop with random stalls, check every pair.
   // -------------------------------------------------------------------------
   initial begin : result_sink
      result_type got;
      int         gap;
      rsp_pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0)
            rx_steady = !rx_steady;
         gap = rx_steady ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         got.first.speed   = rsp_first_speed;
         got.first.status  = rsp_first_status;
         got.second.speed  = rsp_second_speed;
         got.second.status = rsp_second_status;
         got.dump_last     = rsp_dump_last;
         sb.check_pair(got);
         @(negedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      sb = new();
      reset           = 1'b1;
      req_push        = 1'b0;
      req_ignition_on = 1'b0;
      req_speed       = '0;
      req_brake       = 1'b0;
      req_left_turn   = 1'b0;
      req_right_turn  = 1'b0;
      req_high_beam   = 1'b0;
      req_low_beam    = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Short thresholds so the directed part reaches a dump; the write to
      // the spare index must change nothing.
      configure(8'd100, 8'd2, 8'd2);
      write_csr(CSR_SPARE, 8'hAA);

      send_tick(tick_of(1'b0, 8'd255, 5'b11111));  // ignition off: dropped
      send_tick(tick_of(1'b1, 8'd0,   5'b00000));
      send_tick(tick_of(1'b1, 8'd0,   5'b10101));
      send_tick(tick_of(1'b1, 8'd0,   5'b01010));  // long stop, not moving: no dump
      send_tick(tick_of(1'b1, 8'd255, 5'b10000));  // spike: stores previous speed
      send_tick(tick_of(1'b1, 8'd100, 5'b01000));  // exactly at the limit: kept
      send_tick(tick_of(1'b1, 8'd101, 5'b00100));  // just above: replaced, now moving
      send_tick(tick_of(1'b0, 8'd0,   5'b11111));  // ignition off inside the run
      send_tick(tick_of(1'b1, 8'd1,   5'b00010));
      send_tick(tick_of(1'b1, 8'd0,   5'b00001));
      send_tick(tick_of(1'b1, 8'd0,   5'b11111));
      send_tick(tick_of(1'b1, 8'd0,   5'b00000));  // stop after motion: dump of unwritten slots
      send_tick(tick_of(1'b1, 8'd0,   5'b11111));  // stop goes on, no second dump
      send_tick(tick_of(1'b1, 8'd254, 5'b11111));
      send_tick(tick_of(1'b1, 8'd0,   5'b01110));
      wait_for_dumps(SETTLE_CYCLES);

      // Spike limit zero: every nonzero speed is replaced; thresholds are one.
      configure(8'd0, 8'd1, 8'd1);
      run_phase(70);
      wait_for_dumps(SETTLE_CYCLES);

      // Zero thresholds act on the first tick; no speed counts as a spike.
      configure(8'd255, 8'd0, 8'd0);
      run_phase(50);
      wait_for_dumps(SETTLE_CYCLES);

      configure(8'($urandom_range(60, 200)), 8'($urandom_range(2, 6)),
                8'($urandom_range(1, 5)));
      run_phase(120);
      wait_for_dumps(SETTLE_CYCLES);

      // Largest thresholds: counters climb but never reach them here.
      configure(8'd200, 8'd255, 8'd255);
      run_phase(40);
      wait_for_dumps(SETTLE_CYCLES);

      configure(SPIKE_LIMIT_RESET, RUN_THRESHOLD_RESET, STOP_THRESHOLD_RESET);
      run_phase(130);

      // Drain, then idle long enough for any stray pair to show up.
      wait_for_dumps(TAIL_CYCLES);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== stop_triggered_sample_history_dump.f =====
hw/rtl/stsh_pkg.sv
hw/rtl/stsh_fifo.sv
hw/rtl/stsh_front.sv
hw/rtl/stsh_back.sv
hw/rtl/stop_triggered_sample_history_dump.sv
test/tb_stop_triggered_sample_history_dump.sv
